>>> hw/rtl/eiuhp_pkg.sv
// Package for the Ethernet/IPv4/UDP header parser.
// Holds the channel item types, header offsets and status codes.
// No dependencies; compile first.
`default_nettype none

package eiuhp_pkg;

  // Header layout, in bytes from the start of the frame
  localparam int DMAC_END      = 6;
  localparam int SMAC_END      = 12;
  localparam int ETH_HDR_LEN   = 14;
  localparam int IHL_POS       = 14;
  localparam int PROTO_POS     = 23;
  localparam int IPSRC_START   = 26;
  localparam int IPDST_START   = 30;
  localparam int IPDST_END     = 34;
  localparam int IP_MIN_LEN    = 20;
  localparam int UDP_PORTS_LEN = 4;
  localparam int UDP_HDR_LEN   = 8;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Parse status codes: deepest layer reached
  localparam logic [1:0] ST_RUNT = 2'd0;
  localparam logic [1:0] ST_ETH  = 2'd1;
  localparam logic [1:0] ST_IPV4 = 2'd2;
  localparam logic [1:0] ST_UDP  = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [1:0]  parse_status;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] udp_source_port;
    logic [15:0] udp_dest_port;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/eiuhp_if.sv
// Valid/ready channel interfaces for the header parser.
// Depends on eiuhp_pkg for the item types.
`default_nettype none

interface eiuhp_in_if;
  logic                valid;
  logic                ready;
  eiuhp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface eiuhp_out_if;
  logic                 valid;
  logic                 ready;
  eiuhp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/eiuhp_hdr.sv
// Header state of the parser: byte offset, captured header fields and the
// per-byte result logic. Depends on eiuhp_pkg.
`default_nettype none

module eiuhp_hdr #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     frame_byte,
  input  wire logic           last_in_frame,
  output eiuhp_pkg::out_item_t result
);
  import eiuhp_pkg::*;

  typedef logic [OFFSET_BITS-1:0] ofs_t;

  ofs_t        ofs_r;
  logic [47:0] dmac_r, dmac_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [5:0]  ihl_bytes_r, ihl_bytes_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] ipsrc_r, ipsrc_nxt;
  logic [31:0] ipdst_r, ipdst_nxt;
  logic [31:0] ports_r, ports_nxt;

  logic [6:0]  udp_start;      // from the stored IHL
  logic [6:0]  ports_end;
  logic [6:0]  pay_start;
  logic [6:0]  udp_start_new;  // from the IHL after this byte
  logic [6:0]  udp_last_hdr;
  logic        udp_ok;
  logic        is_payload;
  logic [1:0]  status;

  // Fixed-offset header capture
  always_comb begin
    dmac_nxt      = dmac_r;
    smac_nxt      = smac_r;
    etype_nxt     = etype_r;
    ihl_bytes_nxt = ihl_bytes_r;
    proto_nxt     = proto_r;
    ipsrc_nxt     = ipsrc_r;
    ipdst_nxt     = ipdst_r;
    priority if (ofs_r < ofs_t'(DMAC_END)) begin
      dmac_nxt = {dmac_r[39:0], frame_byte};
    end else if (ofs_r < ofs_t'(SMAC_END)) begin
      smac_nxt = {smac_r[39:0], frame_byte};
    end else if (ofs_r < ofs_t'(ETH_HDR_LEN)) begin
      etype_nxt = {etype_r[7:0], frame_byte};
    end else if (ofs_r == ofs_t'(IHL_POS)) begin
      ihl_bytes_nxt = {frame_byte[3:0], 2'b00};
    end else if (ofs_r == ofs_t'(PROTO_POS)) begin
      proto_nxt = frame_byte;
    end else if (ofs_r >= ofs_t'(IPSRC_START) && ofs_r < ofs_t'(IPDST_START)) begin
      ipsrc_nxt = {ipsrc_r[23:0], frame_byte};
    end else if (ofs_r >= ofs_t'(IPDST_START) && ofs_r < ofs_t'(IPDST_END)) begin
      ipdst_nxt = {ipdst_r[23:0], frame_byte};
    end else begin
      // other header bytes and payload: nothing captured here
    end
  end

  // UDP header location and payload flag
  always_comb begin
    udp_ok    = (etype_nxt == ETHERTYPE_IPV4) && (ihl_bytes_nxt >= 6'(IP_MIN_LEN)) &&
                (proto_nxt == PROTO_UDP);
    udp_start = 7'(ETH_HDR_LEN) + {1'b0, ihl_bytes_r};
    ports_end = udp_start + 7'(UDP_PORTS_LEN);
    pay_start = udp_start + 7'(UDP_HDR_LEN);
    ports_nxt = ports_r;
    if (udp_ok && ofs_r >= ofs_t'(udp_start) && ofs_r < ofs_t'(ports_end)) begin
      ports_nxt = {ports_r[23:0], frame_byte};
    end
    is_payload = udp_ok && (ofs_r >= ofs_t'(pay_start));
  end

  // Status on the last byte; frame length is offset plus one
  always_comb begin
    udp_start_new = 7'(ETH_HDR_LEN) + {1'b0, ihl_bytes_nxt};
    udp_last_hdr  = udp_start_new + 7'(UDP_HDR_LEN - 1);
    priority if (ofs_r < ofs_t'(ETH_HDR_LEN - 1)) begin
      status = ST_RUNT;
    end else if (etype_nxt != ETHERTYPE_IPV4 ||
                 ofs_r < ofs_t'(ETH_HDR_LEN + IP_MIN_LEN - 1)) begin
      status = ST_ETH;
    end else if (udp_ok && ofs_r >= ofs_t'(udp_last_hdr)) begin
      status = ST_UDP;
    end else begin
      status = ST_IPV4;
    end
  end

  // Result item; layers not reached read as zero
  always_comb begin
    result               = '0;
    result.payload_byte  = is_payload ? frame_byte : 8'd0;
    result.payload_valid = is_payload;
    result.frame_done    = last_in_frame;
    if (last_in_frame) begin
      result.parse_status = status;
      if (status != ST_RUNT) begin
        result.dest_mac   = dmac_nxt;
        result.source_mac = smac_nxt;
        result.ether_type = etype_nxt;
      end
      if (status == ST_IPV4 || status == ST_UDP) begin
        result.ip_protocol = proto_nxt;
        result.ip_source   = ipsrc_nxt;
        result.ip_dest     = ipdst_nxt;
      end
      if (status == ST_UDP) begin
        result.udp_source_port = ports_nxt[31:16];
        result.udp_dest_port   = ports_nxt[15:0];
      end
    end
  end

  // State update: clears after every last byte, offset saturates
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_in_frame)) begin
      ofs_r       <= '0;
      dmac_r      <= '0;
      smac_r      <= '0;
      etype_r     <= '0;
      ihl_bytes_r <= '0;
      proto_r     <= '0;
      ipsrc_r     <= '0;
      ipdst_r     <= '0;
      ports_r     <= '0;
    end else if (step) begin
      if (ofs_r != '1) begin
        ofs_r <= ofs_r + ofs_t'(1);
      end
      dmac_r      <= dmac_nxt;
      smac_r      <= smac_nxt;
      etype_r     <= etype_nxt;
      ihl_bytes_r <= ihl_bytes_nxt;
      proto_r     <= proto_nxt;
      ipsrc_r     <= ipsrc_nxt;
      ipdst_r     <= ipdst_nxt;
      ports_r     <= ports_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ethernet_ipv4_udp_header_parser_core.sv
// Top level of the Ethernet/IPv4/UDP header parser.
// Depends on eiuhp_pkg, eiuhp_if (channel interfaces) and eiuhp_hdr.
//
// Takes one frame byte per transfer and returns one result per byte, in
// order. Throughput is one byte per clock while the output is ready; each
// byte passes the input register, then the result register, before its
// result is offered. The result register and the input register form a
// two-entry buffer, so an input transfer can be taken while a finished
// result still waits, if the input register is empty. Payload bytes are
// flagged as they pass; the header fields and parse status appear with the
// byte marked last, after which the parser starts fresh. The byte offset
// counter is OFFSET_BITS wide and saturates.
`default_nettype none

module ethernet_ipv4_udp_header_parser_core #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  eiuhp_in_if.sink    in_ch,
  eiuhp_out_if.source out_ch
);
  import eiuhp_pkg::*;

  logic      in_vld_r;
  in_item_t  in_data_r;
  logic      out_vld_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      advance;

  // Move the held byte forward whenever the result register can take it
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data_r <= in_ch.data;
    end
  end

  eiuhp_hdr #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_hdr (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .frame_byte    (in_data_r.frame_byte),
    .last_in_frame (in_data_r.last_in_frame),
    .result        (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire
